// ===== design/crc_rx_pkg.sv =====
// Shared types, constants and codes of the framed packet receiver.
// Has no dependencies; every other design file imports it.
package crc_rx_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 40;

  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [7:0]  HDR1_RST    = 8'hAA;
  localparam logic [7:0]  HDR2_RST    = 8'h55;
  localparam logic [7:0]  DEV_RST     = 8'h01;
  localparam logic [7:0]  BCAST_RST   = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd5;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic ERR_LENGTH = 1'b0;
  localparam logic ERR_CRC    = 1'b1;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic step;      // process the accepted input item
    logic show_err;  // present the pending error result
    logic start;     // begin payload emission at entry zero
    logic advance;   // move to the next payload entry
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err_pend;
    logic emit_pend;
    logic last;      // result now presented is the final one of its input
  } dp_sts_t;

endpackage

// ===== design/crc_rx_dp.sv =====
// Datapath of the framed packet receiver: config registers, byte parser,
// CRC-16 unit, payload memory and result fields. Imports crc_rx_pkg.
module crc_rx_dp
  import crc_rx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_req_type,
  input  logic [7:0]            in_rx_byte,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  output kind_t                 out_kind,
  output logic [OUT_DATA_W-1:0] out_data
);

  typedef enum logic [8:0] {
    PH_HDR1  = 9'b000000001,
    PH_HDR2  = 9'b000000010,
    PH_ADDR  = 9'b000000100,
    PH_CMD   = 9'b000001000,
    PH_LENLO = 9'b000010000,
    PH_LENHI = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_CRCLO = 9'b010000000,
    PH_CRCHI = 9'b100000000
  } phase_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // configuration
  logic        enable_r;
  logic [7:0]  hdr1_r, hdr2_r, dev_r, bcast_r;
  logic [15:0] tmo_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] idle_r, idle_nxt;

  // result side
  kind_t            kind_r;
  logic             cons_r, code_r;
  logic             pend_err_r, pend_code_r, pend_emit_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       mem [MAX_PAYLOAD];

  logic        cons, perr, pcode, pemit, mem_we;
  logic [15:0] crc_upd, idle_sat, len_full;
  logic [LEN_W-1:0] cnt_inc;
  logic        rep_err;

  assign crc_upd  = crc_byte((phase_r == PH_ADDR) ? CRC_INIT : crc_r, in_rx_byte);
  assign idle_sat = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;
  assign len_full = {in_rx_byte, len_r[7:0]};
  assign cnt_inc  = cnt_r + LEN_W'(1);
  assign rep_err  = (addr_r == dev_r) && (addr_r != bcast_r);

  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    idle_nxt   = idle_r;
    cons       = 1'b1;
    perr       = 1'b0;
    pcode      = ERR_LENGTH;
    pemit      = 1'b0;
    mem_we     = 1'b0;
    if (in_req_type == REQ_TICK) begin
      idle_nxt = idle_sat;
      if (phase_r != PH_HDR1 && idle_sat > tmo_r) begin
        phase_nxt = PH_HDR1; cnt_nxt = '0; crc_nxt = CRC_INIT; crc_lo_nxt = '0;
      end
    end else if (!enable_r) begin
      cons = 1'b0;
    end else begin
      if (phase_r != PH_HDR1) idle_nxt = '0;
      case (phase_r)
        PH_HDR1: begin
          if (in_rx_byte == hdr1_r) begin
            phase_nxt = PH_HDR2;
            idle_nxt  = '0;
          end else begin
            cons = 1'b0;
          end
        end
        PH_HDR2: begin
          if (in_rx_byte == hdr2_r) begin
            phase_nxt = PH_ADDR;
          end else begin
            cnt_nxt = '0; crc_nxt = CRC_INIT; crc_lo_nxt = '0;
            if (in_rx_byte == hdr1_r) begin
              phase_nxt = PH_HDR2;
            end else begin
              phase_nxt = PH_HDR1;
              cons      = 1'b0;
            end
          end
        end
        PH_ADDR: begin
          addr_nxt = in_rx_byte; crc_nxt = crc_upd; phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          cmd_nxt = in_rx_byte; crc_nxt = crc_upd; phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_nxt = {8'd0, in_rx_byte}; crc_nxt = crc_upd; phase_nxt = PH_LENHI;
        end
        PH_LENHI: begin
          len_nxt = len_full;
          crc_nxt = crc_upd;
          if (len_full > 16'(MAX_PAYLOAD)) begin
            if (rep_err) begin
              perr  = 1'b1;
              pcode = ERR_LENGTH;
            end
            phase_nxt = PH_HDR1; cnt_nxt = '0; crc_nxt = CRC_INIT; crc_lo_nxt = '0;
          end else if (len_full == 16'd0) begin
            phase_nxt = PH_CRCLO;
          end else begin
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          mem_we  = (cnt_r < LEN_W'(MAX_PAYLOAD));
          cnt_nxt = cnt_inc;
          crc_nxt = crc_upd;
          if (16'(cnt_inc) >= len_r) phase_nxt = PH_CRCLO;
        end
        PH_CRCLO: begin
          crc_lo_nxt = in_rx_byte; phase_nxt = PH_CRCHI;
        end
        PH_CRCHI: begin
          if ({in_rx_byte, crc_lo_r} == crc_r) begin
            pemit = (addr_r == dev_r) || (addr_r == bcast_r);
          end else if (rep_err) begin
            perr  = 1'b1;
            pcode = ERR_CRC;
          end
          phase_nxt = PH_HDR1; cnt_nxt = '0; crc_nxt = CRC_INIT; crc_lo_nxt = '0;
        end
        default: begin
          phase_nxt = PH_HDR1; cnt_nxt = '0; crc_nxt = CRC_INIT; crc_lo_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      hdr1_r   <= HDR1_RST;
      hdr2_r   <= HDR2_RST;
      dev_r    <= DEV_RST;
      bcast_r  <= BCAST_RST;
      tmo_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:  enable_r <= cfg_wdata[0];
        CFG_HDR1:    hdr1_r   <= cfg_wdata[7:0];
        CFG_HDR2:    hdr2_r   <= cfg_wdata[7:0];
        CFG_DEV:     dev_r    <= cfg_wdata[7:0];
        CFG_BCAST:   bcast_r  <= cfg_wdata[7:0];
        CFG_TIMEOUT: tmo_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      addr_r      <= '0;
      cmd_r       <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      crc_r       <= CRC_INIT;
      crc_lo_r    <= '0;
      idle_r      <= '0;
      kind_r      <= KIND_STATUS;
      cons_r      <= 1'b0;
      code_r      <= ERR_LENGTH;
      pend_err_r  <= 1'b0;
      pend_code_r <= ERR_LENGTH;
      pend_emit_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cmd.step) begin
        phase_r  <= phase_nxt;
        addr_r   <= addr_nxt;
        cmd_r    <= cmd_nxt;
        len_r    <= len_nxt;
        cnt_r    <= cnt_nxt;
        crc_r    <= crc_nxt;
        crc_lo_r <= crc_lo_nxt;
        idle_r   <= idle_nxt;
        if (in_req_type == REQ_BYTE) begin
          kind_r      <= KIND_STATUS;
          cons_r      <= cons;
          pend_err_r  <= perr;
          pend_code_r <= pcode;
          pend_emit_r <= pemit;
        end
      end
      if (cmd.show_err) begin
        kind_r <= KIND_ERROR;
        code_r <= pend_code_r;
      end
      if (cmd.start) begin
        kind_r <= KIND_PAYLOAD;
        idx_r  <= '0;
      end
      if (cmd.advance) idx_r <= idx_r + IDX_W'(1);
    end
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.step && in_req_type == REQ_BYTE && mem_we) mem[cnt_r[IDX_W-1:0]] <= in_rx_byte;
    rd_data_r <= mem[idx_r];
  end

  logic [LEN_W-1:0] emit_len;
  logic             empty;
  assign emit_len = len_r[LEN_W-1:0];
  assign empty    = (emit_len == '0);

  always_comb begin
    sts.err_pend  = pend_err_r;
    sts.emit_pend = pend_emit_r;
    case (kind_r)
      KIND_STATUS:  sts.last = !(pend_err_r || pend_emit_r);
      KIND_PAYLOAD: sts.last = empty || ((LEN_W'(idx_r) + LEN_W'(1)) == emit_len);
      default:      sts.last = 1'b1;
    endcase
  end

  // tdata from bit 0 up: consumed, address, command, length, data, valid, error code
  always_comb begin
    out_data = '0;
    case (kind_r)
      KIND_STATUS: out_data[0] = cons_r;
      KIND_PAYLOAD: begin
        out_data[8:1]   = addr_r;
        out_data[16:9]  = cmd_r;
        out_data[22:17] = emit_len;
        out_data[30:23] = empty ? 8'd0 : rd_data_r;
        out_data[31]    = !empty;
      end
      KIND_ERROR: begin
        out_data[16:9] = cmd_r;
        out_data[32]   = code_r;
      end
      default: ;
    endcase
  end

  assign out_kind = kind_r;

endmodule

// ===== design/crc_rx_ctrl.sv =====
// Handshake sequencer of the framed packet receiver.
// Drives datapath commands from crc_rx_pkg; reads datapath status.
module crc_rx_ctrl
  import crc_rx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_req_type,
  input  logic      out_tready,
  input  dp_sts_t   sts,
  output logic      in_tready,
  output logic      out_tvalid,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STAT = 4'b0010,
    S_RD   = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.step = 1'b1;
          if (in_req_type == REQ_BYTE) state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (out_tready) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else if (sts.err_pend) begin
            cmd.show_err = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_tready) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_STAT) || (state_r == S_EMIT);

endmodule

// ===== design/crc_framed_packet_receiver_core.sv =====
// A byte transfer shows its status result in the cycle after the transfer; a tick gives
// no result and leaves the sequencer idle. The input is held off while the results of a
// byte are shown, also while out_tready is low; each payload result after the status is
// read from memory, then shown, and an error result is shown directly.
// Reset (rst_n low, synchronous): registers to defaults, receiver disabled, parser
// hunting for the header; the payload memory is not cleared.
module crc_framed_packet_receiver_core
  import crc_rx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] req_type (1 = millisecond tick)
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] consumed, [8:1] frame_address,
                                            // [16:9] frame_command, [22:17] payload_len,
                                            // [30:23] data_byte, [31] data_valid,
                                            // [32] fault_code, [39:33] zero
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast   // last result caused by its input
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  kind_t     kind;

  // The sequencer owns the handshakes: it takes one item at a time in idle,
  // then holds the input off until every result of that item is transferred.
  crc_rx_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_req_type (in_tuser),
    .out_tready  (out_tready),
    .sts         (sts),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .cmd         (cmd)
  );

  // The datapath parses the byte in the transfer cycle (CRC of one byte in one step),
  // keeps the payload in a small memory and composes the result fields from registers.
  crc_rx_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_req_type (in_tuser),
    .in_rx_byte  (in_tdata[7:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_kind    (kind),
    .out_data    (out_tdata)
  );

  assign out_tuser = kind;
  assign out_tlast = sts.last;

endmodule

// ===== design/crc_rx_chk.sv =====
// Port-level checker for crc_framed_packet_receiver_core, bound to the top level.
// Depends on crc_rx_pkg for the input and result codes.
module crc_rx_chk
  import crc_rx_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  // one item at a time: never take input while a result is shown
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // a byte transfer produces its status result next cycle
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == REQ_BYTE) |=>
      (out_tvalid && out_tuser == KIND_STATUS))
    else $error("byte transfer without status result");

  // a tick produces nothing and frees the input at once
  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == REQ_TICK) |=> (in_tready && !out_tvalid))
    else $error("tick produced a result or stalled the input");

  // an error result always ends its run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ERROR) |-> out_tlast)
    else $error("error result not marked last");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind crc_framed_packet_receiver_core crc_rx_chk u_chk (.*);

// ===== bench/crc_rx_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the framed packet receiver: shadows the register file and the
// parser, predicts every result stream transfer and compares it field by field.
// Depends on crc_rx_pkg; also holds the small CRC helper package shared with the bench.
package crc_rx_tb_pkg;
  import crc_rx_pkg::*;

  // One byte step of CRC-16/MODBUS, LSB first.
  function automatic logic [15:0] crc16_modbus_update(input logic [15:0] crc,
                                                      input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage

module crc_rx_result_checker
  import crc_rx_pkg::*;
  import crc_rx_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int unsigned           mismatch_count,
  output int unsigned           pending_results
);

  typedef enum logic [3:0] {
    PH_HUNT_FIRST,
    PH_HUNT_SECOND,
    PH_ADDRESS,
    PH_COMMAND,
    PH_LENGTH_LO,
    PH_LENGTH_HI,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } parse_phase_t;

  typedef struct packed {
    kind_t       kind;
    logic        consumed;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [5:0]  length;
    logic [7:0]  data;
    logic        data_valid;
    logic        fault_code;
    logic        last;
  } frame_result_t;

  // register shadow
  logic        rx_enable;
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [7:0]  own_address;
  logic [7:0]  bcast_address;
  logic [15:0] timeout_limit;

  // parser shadow
  parse_phase_t phase;
  logic [7:0]   frame_addr;
  logic [7:0]   frame_cmd;
  logic [15:0]  frame_len;
  logic [7:0]   payload_mem [MAX_PAYLOAD];
  logic [5:0]   byte_count;
  logic [15:0]  crc_acc;
  logic [7:0]   crc_low;
  logic [15:0]  tick_count;

  frame_result_t expected_results[$];
  int unsigned   mismatches = 0;

  function automatic frame_result_t blank_result(input kind_t k);
    frame_result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic bit errors_reported();
    return frame_addr == own_address && frame_addr != bcast_address;
  endfunction

  task automatic restart_parser();
    phase      = PH_HUNT_FIRST;
    byte_count = '0;
    crc_acc    = CRC_INIT;
    crc_low    = '0;
  endtask

  task automatic predict_item(input logic is_tick, input logic [7:0] b);
    frame_result_t extra[$];
    frame_result_t r;
    logic          took;
    logic [15:0]   rx_crc;
    took = 1'b1;
    if (is_tick) begin
      if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
      if (phase != PH_HUNT_FIRST && tick_count > timeout_limit) restart_parser();
      return;
    end
    if (!rx_enable) begin
      took = 1'b0;
    end else begin
      if (phase != PH_HUNT_FIRST) tick_count = '0;
      case (phase)
        PH_HUNT_FIRST: begin
          if (b == hdr_first) begin
            phase      = PH_HUNT_SECOND;
            tick_count = '0;
          end else begin
            took = 1'b0;
          end
        end
        PH_HUNT_SECOND: begin
          if (b == hdr_second) begin
            phase = PH_ADDRESS;
          end else begin
            restart_parser();
            if (b == hdr_first) phase = PH_HUNT_SECOND;
            else took = 1'b0;
          end
        end
        PH_ADDRESS: begin
          frame_addr = b;
          crc_acc    = crc16_modbus_update(CRC_INIT, b);
          phase      = PH_COMMAND;
        end
        PH_COMMAND: begin
          frame_cmd = b;
          crc_acc   = crc16_modbus_update(crc_acc, b);
          phase     = PH_LENGTH_LO;
        end
        PH_LENGTH_LO: begin
          frame_len = {8'h00, b};
          crc_acc   = crc16_modbus_update(crc_acc, b);
          phase     = PH_LENGTH_HI;
        end
        PH_LENGTH_HI: begin
          frame_len[15:8] = b;
          crc_acc         = crc16_modbus_update(crc_acc, b);
          if (frame_len > MAX_PAYLOAD) begin
            if (errors_reported()) begin
              r            = blank_result(KIND_ERROR);
              r.command    = frame_cmd;
              r.fault_code = ERR_LENGTH;
              extra.push_back(r);
            end
            restart_parser();
          end else if (frame_len == 16'd0) begin
            phase = PH_CRC_LO;
          end else begin
            byte_count = '0;
            phase      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (byte_count < MAX_PAYLOAD) payload_mem[byte_count] = b;
          byte_count = byte_count + 6'd1;
          crc_acc    = crc16_modbus_update(crc_acc, b);
          if (byte_count >= frame_len) phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_low = b;
          phase   = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          rx_crc = {b, crc_low};
          if (rx_crc == crc_acc) begin
            if (frame_addr == own_address || frame_addr == bcast_address) begin
              r         = blank_result(KIND_PAYLOAD);
              r.address = frame_addr;
              r.command = frame_cmd;
              if (frame_len == 16'd0) begin
                extra.push_back(r);
              end else begin
                r.length     = frame_len[5:0];
                r.data_valid = 1'b1;
                for (int i = 0; i < frame_len; i++) begin
                  r.data = payload_mem[i];
                  extra.push_back(r);
                end
              end
            end
          end else if (errors_reported()) begin
            r            = blank_result(KIND_ERROR);
            r.command    = frame_cmd;
            r.fault_code = ERR_CRC;
            extra.push_back(r);
          end
          restart_parser();
        end
        default: restart_parser();
      endcase
    end
    r          = blank_result(KIND_STATUS);
    r.consumed = took;
    r.last     = (extra.size() == 0);
    expected_results.push_back(r);
    foreach (extra[i]) begin
      r      = extra[i];
      r.last = (i == extra.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst_n) begin
      rx_enable     = 1'b0;
      hdr_first     = HDR1_RST;
      hdr_second    = HDR2_RST;
      own_address   = DEV_RST;
      bcast_address = BCAST_RST;
      timeout_limit = TIMEOUT_RST;
      frame_addr    = '0;
      frame_cmd     = '0;
      frame_len     = '0;
      tick_count    = '0;
      restart_parser();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:  rx_enable     = cfg_wdata[0];
          CFG_HDR1:    hdr_first     = cfg_wdata[7:0];
          CFG_HDR2:    hdr_second    = cfg_wdata[7:0];
          CFG_DEV:     own_address   = cfg_wdata[7:0];
          CFG_BCAST:   bcast_address = cfg_wdata[7:0];
          CFG_TIMEOUT: timeout_limit = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_item(in_tuser == REQ_TICK, in_tdata[7:0]);
      if (out_tvalid && out_tready) begin
        got.kind       = kind_t'(out_tuser);
        got.consumed   = out_tdata[0];
        got.address    = out_tdata[8:1];
        got.command    = out_tdata[16:9];
        got.length     = out_tdata[22:17];
        got.data       = out_tdata[30:23];
        got.data_valid = out_tdata[31];
        got.fault_code = out_tdata[32];
        got.last       = out_tlast;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected (kind %0d)", out_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("consumed", want.consumed, got.consumed);
          check_field("frame_address", want.address, got.address);
          check_field("frame_command", want.command, got.command);
          check_field("payload_len", want.length, got.length);
          check_field("data_byte", want.data, got.data);
          check_field("data_valid", want.data_valid, got.data_valid);
          check_field("fault_code", want.fault_code, got.fault_code);
          check_field("last", want.last, got.last);
        end
      end
    end
    mismatch_count  <= mismatches;
    pending_results <= expected_results.size();
  end

endmodule

// ===== bench/tb_crc_framed_packet_receiver_core.sv =====
`timescale 1ns / 1ps
// Top of the framed packet receiver bench: clock, reset, register programming,
// byte and tick stimulus, output backpressure and the final verdict.
// Depends on crc_rx_pkg, crc_rx_tb_pkg and crc_rx_result_checker.
module tb_crc_framed_packet_receiver_core;
  import crc_rx_pkg::*;
  import crc_rx_tb_pkg::*;

  localparam int  HOLD_OFF_CYCLES = 400;     // long receiver hold-off
  localparam int  SETTLE_CYCLES   = 8;       // a tick may still be in flight
  localparam int  DRAIN_LIMIT     = 100000;  // cycles to wait for outstanding results
  localparam int  RUN_LIMIT_NS    = 10000000;
  localparam int  BUSY_PCT        = 34;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  int unsigned mismatch_count;
  int unsigned pending_results;

  // idle percentage shared by both sides; zero gives a stretch with no gaps
  int idle_pct  = BUSY_PCT;
  int items_sent = 0;

  // receiver hold-off request (written by stimulus) and completion (receiver side)
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;

  // current register values, used to build well-formed frames
  logic        cur_enable  = 1'b0;
  logic [7:0]  cur_hdr1    = HDR1_RST;
  logic [7:0]  cur_hdr2    = HDR2_RST;
  logic [7:0]  cur_dev     = DEV_RST;
  logic [7:0]  cur_bcast   = BCAST_RST;
  logic [15:0] cur_timeout = TIMEOUT_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  crc_framed_packet_receiver_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] rx_byte
    .in_tuser   (in_tuser),   // [0] req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] consumed .. [32] fault_code, rest zero
    .out_tuser  (out_tuser),  // [1:0] kind
    .out_tlast  (out_tlast)
  );

  crc_rx_result_checker frame_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Receiver: random backpressure, plus one long hold-off counted here once
  // requested, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_count == HOLD_OFF_CYCLES) begin
        hold_done  <= 1'b1;
        out_tready <= 1'b1;
      end else begin
        hold_count <= hold_count + 1;
        out_tready <= 1'b0;
      end
    end else begin
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Offer one item and hold it until the transfer. Valid stays high on return,
  // so back-to-back items never drop and raise it in the same step.
  task automatic send_item(input logic is_tick, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_tick;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(REQ_BYTE, b);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic maybe_tick(input int pct);
    if ($urandom_range(0, 99) < pct) send_ticks(1);
  endtask

  // Drop valid, wait for every predicted result, then let a trailing tick settle.
  task automatic drain();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers on consecutive cycles; only call while idle.
  task automatic program_receiver(input logic en, input logic [7:0] h1, input logic [7:0] h2,
                                  input logic [7:0] dev, input logic [7:0] bc,
                                  input logic [15:0] tmo);
    cur_enable  = en;
    cur_hdr1    = h1;
    cur_hdr2    = h2;
    cur_dev     = dev;
    cur_bcast   = bc;
    cur_timeout = tmo;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_wdata <= {15'd0, en};
    @(posedge clk);
    cfg_index <= CFG_HDR1;
    cfg_wdata <= {8'd0, h1};
    @(posedge clk);
    cfg_index <= CFG_HDR2;
    cfg_wdata <= {8'd0, h2};
    @(posedge clk);
    cfg_index <= CFG_DEV;
    cfg_wdata <= {8'd0, dev};
    @(posedge clk);
    cfg_index <= CFG_BCAST;
    cfg_wdata <= {8'd0, bc};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Header, address, command, length, payload and CRC; oversize lengths stop
  // after the length since the parser resets there. mid_ticks go after the address.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [15:0] len, input bit good_crc,
                            input int tick_pct, input int mid_ticks);
    logic [7:0]  body[$];
    logic [15:0] crc;
    body.push_back(addr);
    body.push_back(cmd);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    if (len <= MAX_PAYLOAD) repeat (len) body.push_back(8'($urandom_range(0, 255)));
    crc = CRC_INIT;
    foreach (body[i]) crc = crc16_modbus_update(crc, body[i]);
    if (!good_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(cur_hdr1);
    maybe_tick(tick_pct);
    send_byte(cur_hdr2);
    foreach (body[i]) begin
      maybe_tick(tick_pct);
      send_byte(body[i]);
      if (i == 0) send_ticks(mid_ticks);
    end
    if (len <= MAX_PAYLOAD) begin
      maybe_tick(tick_pct);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
    end
  endtask

  // Mostly short payloads, a few at the maximum, some oversize.
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 8));
    if (r < 85) return 16'($urandom_range(9, MAX_PAYLOAD - 1));
    if (r < 90) return 16'(MAX_PAYLOAD);
    if (r < 95) return 16'($urandom_range(MAX_PAYLOAD + 1, 63));
    return 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
  endfunction

  function automatic logic [7:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return cur_dev;
    if (r < 70) return cur_bcast;
    return 8'($urandom_range(0, 255));
  endfunction

  // Random traffic: mostly well-formed frames with random content, the rest
  // noise bytes, truncated frames and tick bursts.
  task automatic run_traffic(input int goal);
    int start;
    int r;
    int n;
    start = items_sent;
    while (items_sent - start < goal) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(pick_address(), 8'($urandom_range(0, 255)), pick_length(),
                   ($urandom_range(0, 99) < 78), 3, 0);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 99) < 30) send_byte(cur_hdr1);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end else if (r < 90) begin
        // cut the frame short and let the timeout expire where it is short
        send_byte(cur_hdr1);
        send_byte(cur_hdr2);
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
        n = (cur_timeout <= 30) ? int'(cur_timeout) + 1 : $urandom_range(1, 3);
        send_ticks(n);
      end else begin
        send_ticks($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    logic [7:0] rnd_hdr;
    logic [7:0] rnd_addr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // receiver disabled out of reset: byte not consumed, tick still counted
    send_byte(8'hAA);
    send_ticks(1);
    drain();

    program_receiver(1'b1, 8'hAA, 8'h55, 8'h01, 8'hFF, TIMEOUT_RST);
    // hunting: a non-header byte is not consumed
    send_byte(8'h00);
    // wrong second header byte that is not the first header: not consumed
    send_byte(8'hAA);
    send_byte(8'hFF);
    // repeated first header byte keeps waiting for the second; then an empty frame
    send_byte(8'hAA);
    send_frame(8'h01, 8'hFF, 16'd0, 1'b1, 0, 0);
    // oversize length to the device address
    send_frame(8'h01, 8'h5A, 16'hFFFF, 1'b1, 0, 0);
    // CRC mismatch to the device address
    send_frame(8'h01, 8'h00, 16'd1, 1'b0, 0, 0);
    drain();

    // timeout: two ticks beyond a one-tick limit drop the partial frame
    program_receiver(1'b1, 8'hAA, 8'h55, 8'h01, 8'hFF, 16'd1);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h01);
    send_ticks(2);
    send_byte(8'h01);
    drain();

    // reset-like setting with a long receiver hold-off under a full-size frame
    program_receiver(1'b1, 8'hAA, 8'h55, 8'h01, 8'hFF, TIMEOUT_RST);
    hold_req = 1'b1;
    send_frame(cur_dev, 8'($urandom_range(0, 255)), 16'(MAX_PAYLOAD), 1'b1, 0, 0);
    run_traffic(30);
    drain();

    // extremes of the header and address registers, zero timeout
    program_receiver(1'b1, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'd0);
    run_traffic(20);
    drain();

    program_receiver(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'hFFFF);
    run_traffic(20);
    drain();

    // equal header bytes and device address equal to broadcast: no errors reported
    rnd_hdr  = 8'($urandom_range(0, 255));
    rnd_addr = 8'($urandom_range(0, 255));
    program_receiver(1'b1, rnd_hdr, rnd_hdr, rnd_addr, rnd_addr, 16'd5);
    run_traffic(20);
    drain();

    // disabled with random registers
    program_receiver(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)));
    run_traffic(10);
    drain();

    program_receiver(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(1, 30)));
    run_traffic(25);
    drain();

    // never-expiring timeout with no idling on either side: ticks inside a frame
    // leave it intact, then a stretch of random traffic
    idle_pct = 0;
    program_receiver(1'b1, 8'hAA, 8'h55, 8'h01, 8'hFF, 16'hFFFF);
    send_frame(8'h01, 8'($urandom_range(0, 255)), 16'd4, 1'b1, 0, 3);
    run_traffic(20);
    idle_pct = BUSY_PCT;
    drain();

    if (pending_results != 0) begin
      $error("%0d expected results never arrived", pending_results);
    end
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_crc_framed_packet_receiver_core: done, clean");
    end else begin
      $display("tb_crc_framed_packet_receiver_core: done, errors");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_crc_framed_packet_receiver_core: done, errors");
    $finish;
  end

endmodule

// ===== crc_framed_packet_receiver_core.f =====
design/crc_rx_pkg.sv
design/crc_rx_dp.sv
design/crc_rx_ctrl.sv
design/crc_framed_packet_receiver_core.sv
design/crc_rx_chk.sv
bench/crc_rx_result_checker.sv
bench/tb_crc_framed_packet_receiver_core.sv
